FILE: hdl/hist_pkg.sv
// Shared widths, constants and register codes for the histogram block.
package hist_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int SHARE_W  = 14;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // hundredths of a percent per unit share
    localparam logic [SHARE_W-1:0] SCALE = 14'd10000;

    localparam logic signed [SAMPLE_W-1:0] LOW_RESET  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] HIGH_RESET = 16'sd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_BOUND  = 1'b0,
        REG_HIGH_BOUND = 1'b1
    } t_reg_idx;

endpackage

FILE: hdl/hist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hist_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/hist_div.sv
// Iterative share unit: count * 10000 / total, one quotient bit per cycle.
module hist_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [COUNT_BITS-1:0]          i_count,
    input  logic [hist_pkg::TOTAL_W-1:0]   i_total,
    output logic                           o_done,
    output logic [hist_pkg::SHARE_W-1:0]   o_quot
);
    import hist_pkg::*;

    localparam int REM_W  = TOTAL_W + SHARE_W;
    localparam int PROD_W = COUNT_BITS + SHARE_W;
    localparam int STEP_W = $clog2(SHARE_W);

    logic [REM_W-1:0]   r_rem, n_rem;
    logic [REM_W-1:0]   r_dsh, n_dsh;
    logic [SHARE_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [PROD_W-1:0]  prod;
    logic               ge;

    assign prod = PROD_W'(i_count) * PROD_W'(SCALE);
    assign ge   = (r_rem >= r_dsh);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // quotient never exceeds 10000, so SHARE_W steps suffice
            n_rem  = REM_W'(prod);
            n_dsh  = REM_W'(i_total) << (SHARE_W - 1);
            n_quot = '0;
            n_step = STEP_W'(SHARE_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quot = {r_quot[SHARE_W-2:0], ge};
            n_dsh  = r_dsh >> 1;
            n_step = r_step - STEP_W'(1);
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        r_step <= n_step;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: hdl/histogram_with_percentages.sv
// Histogram of signed samples with per-bin share of the in-range total.
//
// A sample is taken when start is high and busy is low. An out-of-range sample
// without last needs only the accept step; an in-range sample goes through
// accept, count read and count write. A sample with last is counted first,
// then every bin from low_bound to the effective high end is emitted, lowest
// first, one word per bin with o_valid high for a single cycle; the receiver
// must take it then. The shared divider produces one bit of the 14-bit share
// per cycle. busy stays high until the final bin's word is out. Counts and
// total are cleared as the final word goes out, on a last sample with an
// empty range, and at reset, through per-bin valid flags, so no clearing pass
// is needed. Write low_bound and high_bound only while busy is low.
module histogram_with_percentages #(
    parameter int BINS       = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [hist_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hist_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [hist_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last,
    output logic                                 o_valid,
    output logic signed [hist_pkg::SAMPLE_W-1:0] o_bin_value,
    output logic [hist_pkg::SAMPLE_W-1:0]        o_bin_count,
    output logic [hist_pkg::SHARE_W-1:0]         o_share_hundredths,
    output logic                                 o_final_bin
);
    import hist_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int EXT_W = SAMPLE_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_UPD  = 6'b000100,
        S_ERD  = 6'b001000,
        S_LOAD = 6'b010000,
        S_DIV  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]           r_addr, n_addr;
    logic                       r_last, n_last;
    logic [BINS-1:0]            r_vld, n_vld;
    logic [TOTAL_W-1:0]         r_total, n_total;
    logic signed [SAMPLE_W-1:0] r_low, n_low;
    logic signed [SAMPLE_W-1:0] r_high, n_high;

    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value, n_out_value;
    logic [SAMPLE_W-1:0]        r_out_count, n_out_count;
    logic [SHARE_W-1:0]         r_out_share, n_out_share;
    logic                       r_out_final, n_out_final;

    logic signed [EXT_W-1:0] low_x, high_x, samp_x, cap_x, hi_end;
    logic                    empty, in_rng;
    logic [IDX_W-1:0]        last_idx;
    logic [COUNT_BITS-1:0]   rd_data, cur_cnt, inc_cnt;
    logic [31:0]             cnt_ext;
    logic                    ram_we;
    logic                    div_start, div_done;
    logic [SHARE_W-1:0]      div_quot;

    assign low_x    = EXT_W'(r_low);
    assign high_x   = EXT_W'(r_high);
    assign samp_x   = EXT_W'(i_sample);
    assign cap_x    = low_x + EXT_W'(BINS - 1);
    assign hi_end   = (high_x < cap_x) ? high_x : cap_x;
    assign empty    = (high_x < low_x);
    assign in_rng   = (samp_x >= low_x) && (samp_x <= hi_end);
    assign last_idx = IDX_W'(hi_end - low_x);

    // a bin not yet written since the last clear reads as zero
    assign cur_cnt = r_vld[r_addr] ? rd_data : '0;
    assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
    assign cnt_ext = 32'(cur_cnt);

    hist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (inc_cnt),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    hist_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (cur_cnt),
        .i_total (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_vld       = r_vld;
        n_total     = r_total;
        n_low       = r_low;
        n_high      = r_high;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_share = r_out_share;
        n_out_final = r_out_final;
        ram_we      = 1'b0;
        div_start   = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOW_BOUND:  n_low  = i_cfg_data;
                REG_HIGH_BOUND: n_high = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_addr = IDX_W'(samp_x - low_x);
                    n_last = i_last;
                    if (in_rng) begin
                        n_state = S_RD;
                    end else if (i_last) begin
                        if (empty) begin
                            n_vld   = '0;
                            n_total = '0;
                        end else begin
                            n_addr  = '0;
                            n_state = S_ERD;
                        end
                    end
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                ram_we        = 1'b1;
                n_vld[r_addr] = 1'b1;
                if (r_total != '1) begin
                    n_total = r_total + TOTAL_W'(1);
                end
                if (r_last) begin
                    n_addr  = '0;
                    n_state = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERD: n_state = S_LOAD;
            S_LOAD: begin
                div_start   = 1'b1;
                n_out_count = cnt_ext[SAMPLE_W-1:0];
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_low + SAMPLE_W'(r_addr);
                    n_out_share = (r_total == '0) ? '0 : div_quot;
                    n_out_final = (r_addr == last_idx);
                    if (r_addr == last_idx) begin
                        n_vld   = '0;
                        n_total = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + IDX_W'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_total     <= '0;
            r_low       <= LOW_RESET;
            r_high      <= HIGH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_total     <= n_total;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
        r_addr      <= n_addr;
        r_last      <= n_last;
        r_out_value <= n_out_value;
        r_out_count <= n_out_count;
        r_out_share <= n_out_share;
        r_out_final <= n_out_final;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_bin_value        = r_out_value;
    assign o_bin_count        = r_out_count;
    assign o_share_hundredths = r_out_share;
    assign o_final_bin        = r_out_final;

`ifndef SYNTHESIS
    a_share_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_share_hundredths <= SCALE))
        else $error("share above 10000");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_bin) |-> (!busy && r_total == '0 && r_vld == '0))
        else $error("store not cleared after final word");

    a_words_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back words");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_total) == '0) |-> (o_share_hundredths == '0))
        else $error("nonzero share with empty total");

    a_word_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(div_done && r_state == S_DIV))
        else $error("word without divider result");
`endif
endmodule

FILE: verif/histogram_with_percentages_tb.sv
// Self-checking testbench for histogram_with_percentages: directed table, then random sample sets.
module histogram_with_percentages_tb;
    import hist_pkg::*;

    localparam int BIN_SLOTS = 64;
    localparam int COUNT_TOP = 65535;
    localparam longint unsigned TOTAL_TOP = 64'hFFFF_FFFF;
    localparam int RAND_ITEMS = 230;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0]        count;
        logic [SHARE_W-1:0]         share;
        logic                       fin;
    } t_bin_word;

    typedef enum logic {ROW_BOUNDS, ROW_SAMPLE} t_row_kind;

    // a/b: low/high for a bounds row; a is the sample for a sample row
    typedef struct packed {
        t_row_kind                  kind;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic                       last;
        logic                       typed;
        t_bin_word                  want;
    } t_stim_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        i_last;
    logic                        o_valid;
    logic signed [SAMPLE_W-1:0]  o_bin_value;
    logic [SAMPLE_W-1:0]         o_bin_count;
    logic [SHARE_W-1:0]          o_share_hundredths;
    logic                        o_final_bin;

    // histogram mirror
    int unsigned        hist_counts [BIN_SLOTS];
    longint unsigned    in_range_total;
    logic signed [15:0] low_q;
    logic signed [15:0] high_q;
    t_bin_word          bins_due [$];
    t_bin_word          due_word;
    int                 mismatches = 0;
    int                 idle_pct = 0;

    t_stim_row plan [26] = '{
        '{ROW_SAMPLE, 16'sd0,   16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd63,  16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd64,  16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, -16'sd1,  16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd63,  16'sd0, 1'b1, 1'b0, '0},
        // single bin at the bottom of the value range
        '{ROW_BOUNDS, 16'h8000, 16'h8000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8000, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h7FFF, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8000, 16'sd0, 1'b1, 1'b1, '{16'h8000, 16'd2, 14'd10000, 1'b1}},
        // nothing in range: zero count, zero share
        '{ROW_SAMPLE, 16'sd0,   16'sd0, 1'b1, 1'b1, '{16'h8000, 16'd0, 14'd0, 1'b1}},
        '{ROW_BOUNDS, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h7FFF, 16'sd0, 1'b1, 1'b1, '{16'h7FFF, 16'd1, 14'd10000, 1'b1}},
        // high below low: no bins, no words
        '{ROW_BOUNDS, 16'sd5,   16'sd4, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd5,   16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd4,   16'sd0, 1'b1, 1'b0, '0},
        // full span: bins capped at low + 63
        '{ROW_BOUNDS, 16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8000, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h803F, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8040, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8001, 16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'h8001, 16'sd0, 1'b1, 1'b0, '0},
        '{ROW_BOUNDS, -16'sd3,  16'sd2, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, -16'sd3,  16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd2,   16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd2,   16'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 16'sd0,   16'sd0, 1'b1, 1'b0, '0}
    };

    histogram_with_percentages uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_sample           (i_sample),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .o_bin_value        (o_bin_value),
        .o_bin_count        (o_bin_count),
        .o_share_hundredths (o_share_hundredths),
        .o_final_bin        (o_final_bin)
    );

    always #10 i_clk = ~i_clk;

    function automatic int top_bin();
        int lo;
        lo = low_q;
        return (high_q < lo + BIN_SLOTS - 1) ? int'(high_q) : lo + BIN_SLOTS - 1;
    endfunction

    function void clear_hist();
        foreach (hist_counts[i]) hist_counts[i] = 0;
        in_range_total = 0;
    endfunction

    // count one sample; on last, queue one word per bin when emit is set, and clear
    function void tally_sample(input logic signed [15:0] s, input logic last, input bit emit);
        int lo;
        int hi;
        int v;
        longint unsigned c;
        longint unsigned share;
        t_bin_word w;
        lo = low_q;
        hi = top_bin();
        v = s;
        if (v >= lo && v <= hi) begin
            if (hist_counts[v - lo] < COUNT_TOP) hist_counts[v - lo]++;
            if (in_range_total < TOTAL_TOP) in_range_total++;
        end
        if (last) begin
            for (int b = lo; b <= hi; b++) begin
                c = hist_counts[b - lo];
                share = (in_range_total == 0) ? 0 : (c * 10000) / in_range_total;
                w.value = b[15:0];
                w.count = c[15:0];
                w.share = share[SHARE_W-1:0];
                w.fin = (b == hi);
                if (emit) bins_due.push_back(w);
            end
            clear_hist();
        end
    endfunction

    function int draw_gap();
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < idle_pct) n++;
        return n;
    endfunction

    function logic signed [15:0] pick_sample();
        int lo;
        int hi;
        int x;
        lo = low_q;
        hi = top_bin();
        if (hi < lo || $urandom_range(4) == 0) begin
            x = $urandom;
        end else begin
            x = lo - 2 + int'($urandom_range(hi - lo + 4));
        end
        return x[15:0];
    endfunction

    // start stays high on return; the caller lowers it through pause
    task put_sample(input logic signed [15:0] s, input logic l, input bit emit);
        start <= 1'b1;
        i_sample <= s;
        i_last <= l;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tally_sample(s, l, emit);
    endtask

    task pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for every expected word and for the block to go idle
    task settle();
        pause(1);
        while (bins_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task set_bounds(input int lo, input int hi);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_LOW_BOUND;
        i_cfg_data <= lo[15:0];
        @(posedge i_clk);
        i_cfg_idx <= REG_HIGH_BOUND;
        i_cfg_data <= hi[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        low_q = lo[15:0];
        high_q = hi[15:0];
    endtask

    task pick_bounds();
        int lo;
        int hi;
        case ($urandom_range(9))
            0: begin
                lo = int'($urandom_range(65535)) - 32768;
                hi = int'($urandom_range(65535)) - 32768;
            end
            1: begin
                lo = -32768;
                hi = lo + int'($urandom_range(80));
            end
            2: begin
                hi = 32767;
                lo = hi - int'($urandom_range(80));
            end
            default: begin
                lo = int'($urandom_range(65535 - 80)) - 32768;
                hi = lo + int'($urandom_range(70));
            end
        endcase
        settle();
        set_bounds(lo, hi);
    endtask

    task check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (bins_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: unexpected word, expected none, got value %0d", $time,
                             o_bin_value);
            end else begin
                due_word = bins_due.pop_front();
                check_field("bin_value", due_word.value, o_bin_value);
                check_field("bin_count", due_word.count, o_bin_count);
                check_field("share_hundredths", due_word.share, o_share_hundredths);
                check_field("final_bin", due_word.fin, o_final_bin);
            end
        end
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int sent;
        int set_len;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_LOW_BOUND;
        i_cfg_data <= '0;
        i_sample <= '0;
        i_last <= 1'b0;
        low_q = LOW_RESET;
        high_q = HIGH_RESET;
        clear_hist();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_BOUNDS) begin
                settle();
                set_bounds(plan[r].a, plan[r].b);
            end else begin
                put_sample(plan[r].a, plan[r].last, !plan[r].typed);
                if (plan[r].typed) bins_due.push_back(plan[r].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 68 : 7;
            sent = 0;
            while (sent < RAND_ITEMS / 3) begin
                pick_bounds();
                repeat ($urandom_range(3, 1)) begin
                    set_len = $urandom_range(12, 1);
                    for (int k = 0; k < set_len; k++) begin
                        put_sample(pick_sample(), k == set_len - 1, 1'b1);
                        pause(draw_gap());
                        sent++;
                    end
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && bins_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
